// ----- rtl/core/epcal_pkg.sv -----
// Shared types, constants and the month length table of the epoch to calendar converter.
package epcal_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAYS,
      ST_HOURS,
      ST_MINS,
      ST_YEARS,
      ST_MONTHS,
      ST_WRITE
   } state_type;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned EPOCH_YEAR    = 1970;

   localparam logic [1:0] EPOCH_MOD4   = 2'(EPOCH_YEAR % 4);
   localparam logic [6:0] EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
   localparam logic [8:0] EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);

   localparam logic [4:0] DAY_STEPS  = 5'd16;
   localparam logic [4:0] HOUR_STEPS = 5'd4;
   localparam logic [4:0] MIN_STEPS  = 5'd5;

   function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
      logic [4:0] len;
      case (idx)
         4'd0:    len = 5'd31;
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- rtl/core/epoch_seconds_to_calendar_core.sv -----
// Top level of the epoch seconds to Gregorian calendar converter.
// Restoring division splits the time into days, hours, minutes and seconds; then years and
// months are stepped off the day count; the write state loads the result, stalling while a
// held result is not taken. One beat at a time: the shared subtract and compare unit serves
// all steps. Range errors skip to the write state. A new beat is taken while a result waits.
// Synchronous active-high reset clears the sequencer, the result valid and the zone offset.
module epoch_seconds_to_calendar_core
   import epcal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_cal_year,
   output logic [3:0]  rsp_cal_month,
   output logic [4:0]  rsp_cal_day,
   output logic [4:0]  rsp_cal_hour,
   output logic [5:0]  rsp_cal_minute,
   output logic [5:0]  rsp_cal_second,
   output logic        rsp_range_error
);

   localparam logic [33:0] DAY_OP  = 34'(SECS_PER_DAY);
   localparam logic [33:0] HOUR_OP = 34'(SECS_PER_HOUR);
   localparam logic [33:0] MIN_OP  = 34'(SECS_PER_MIN);

   state_type state_ff, state_in;
   logic [4:0]  zone_ff;
   logic [33:0] acc_ff, acc_in;
   logic [16:0] q_ff, q_in;
   logic [4:0]  k_ff, k_in;
   logic [16:0] day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [1:0]  y4_ff, y4_in;
   logic [6:0]  y100_ff, y100_in;
   logic [8:0]  y400_ff, y400_in;
   logic        err_ff, err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_load;

   logic [11:0] rsp_cal_year_ff;
   logic [3:0]  rsp_cal_month_ff;
   logic [4:0]  rsp_cal_day_ff;
   logic [4:0]  rsp_cal_hour_ff;
   logic [5:0]  rsp_cal_minute_ff;
   logic [5:0]  rsp_cal_second_ff;
   logic        rsp_range_error_ff;

   logic signed [17:0] offset_secs;
   logic signed [33:0] adj_time;
   logic               leap;
   logic [33:0]        operand;
   logic [34:0]        diff;
   logic               ge;
   logic [16:0]        q_next;

   assign offset_secs = $signed({{13{zone_ff[4]}}, zone_ff}) * 18'sd3600;
   assign adj_time    = $signed({2'b00, req_epoch_seconds})
                      + $signed({{16{offset_secs[17]}}, offset_secs});

   assign leap = (y4_ff == 2'd0) && ((y100_ff != 7'd0) || (y400_ff == 9'd0));

   always_comb begin
      case (state_ff)
         ST_DAYS:   operand = DAY_OP << k_ff;
         ST_HOURS:  operand = HOUR_OP << k_ff;
         ST_MINS:   operand = MIN_OP << k_ff;
         ST_YEARS:  operand = leap ? 34'd366 : 34'd365;
         ST_MONTHS: operand = 34'(month_len(month_ff - 4'd1, leap));
         default:   operand = '0;
      endcase
   end

   assign diff   = {1'b0, acc_ff} - {1'b0, operand};
   assign ge     = ~diff[34];
   assign q_next = {q_ff[15:0], ge};

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      y4_in        = y4_ff;
      y100_in      = y100_ff;
      y400_in      = y400_ff;
      err_in       = err_ff;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               acc_in   = adj_time;
               q_in     = '0;
               k_in     = DAY_STEPS;
               year_in  = 12'(EPOCH_YEAR);
               month_in = 4'd1;
               y4_in    = EPOCH_MOD4;
               y100_in  = EPOCH_MOD100;
               y400_in  = EPOCH_MOD400;
               err_in   = adj_time[33];
               state_in = adj_time[33] ? ST_WRITE : ST_DAYS;
            end
         end
         ST_DAYS: begin
            if (ge) acc_in = diff[33:0];
            q_in = q_next;
            k_in = k_ff - 5'd1;
            if (k_ff == 5'd0) begin
               day_in   = q_next;
               q_in     = '0;
               k_in     = HOUR_STEPS;
               state_in = ST_HOURS;
            end
         end
         ST_HOURS: begin
            if (ge) acc_in = diff[33:0];
            q_in = q_next;
            k_in = k_ff - 5'd1;
            if (k_ff == 5'd0) begin
               hour_in  = q_next[4:0];
               q_in     = '0;
               k_in     = MIN_STEPS;
               state_in = ST_MINS;
            end
         end
         ST_MINS: begin
            q_in = q_next;
            k_in = k_ff - 5'd1;
            if (ge) acc_in = diff[33:0];
            if (k_ff == 5'd0) begin
               minute_in = q_next[5:0];
               second_in = ge ? diff[5:0] : acc_ff[5:0];
               acc_in    = {17'd0, day_ff};
               state_in  = ST_YEARS;
            end
         end
         ST_YEARS: begin
            if (ge) begin
               acc_in  = diff[33:0];
               year_in = year_ff + 12'd1;
               y4_in   = y4_ff + 2'd1;
               y100_in = (y100_ff == 7'd99) ? 7'd0 : y100_ff + 7'd1;
               y400_in = (y400_ff == 9'd399) ? 9'd0 : y400_ff + 9'd1;
            end else begin
               state_in = ST_MONTHS;
            end
         end
         ST_MONTHS: begin
            if (ge && (month_ff != 4'd12)) begin
               acc_in   = diff[33:0];
               month_in = month_ff + 4'd1;
            end else begin
               day_in   = acc_ff[16:0] + 17'd1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         zone_ff      <= 5'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) zone_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      k_ff      <= k_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      y4_ff     <= y4_in;
      y100_ff   <= y100_in;
      y400_ff   <= y400_in;
      err_ff    <= err_in;
      if (out_load) begin
         rsp_range_error_ff <= err_ff;
         rsp_cal_year_ff    <= err_ff ? 12'd0 : year_ff;
         rsp_cal_month_ff   <= err_ff ? 4'd0 : month_ff;
         rsp_cal_day_ff     <= err_ff ? 5'd0 : day_ff[4:0];
         rsp_cal_hour_ff    <= err_ff ? 5'd0 : hour_ff;
         rsp_cal_minute_ff  <= err_ff ? 6'd0 : minute_ff;
         rsp_cal_second_ff  <= err_ff ? 6'd0 : second_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cal_year    = rsp_cal_year_ff;
   assign rsp_cal_month   = rsp_cal_month_ff;
   assign rsp_cal_day     = rsp_cal_day_ff;
   assign rsp_cal_hour    = rsp_cal_hour_ff;
   assign rsp_cal_minute  = rsp_cal_minute_ff;
   assign rsp_cal_second  = rsp_cal_second_ff;
   assign rsp_range_error = rsp_range_error_ff;

endmodule

// ----- rtl/core/epcal_checker.sv -----
// Port-level checks of the epoch to calendar converter and their binding to the top level.
module epcal_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_cal_year,
   input logic [3:0]  rsp_cal_month,
   input logic [4:0]  rsp_cal_day,
   input logic [4:0]  rsp_cal_hour,
   input logic [5:0]  rsp_cal_minute,
   input logic [5:0]  rsp_cal_second,
   input logic        rsp_range_error
);

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again straight after a beat");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> (rsp_cal_year == 12'd0) && (rsp_cal_month == 4'd0)
         && (rsp_cal_day == 5'd0) && (rsp_cal_hour == 5'd0) && (rsp_cal_minute == 6'd0)
         && (rsp_cal_second == 6'd0))
      else $error("range error beat carries non-zero fields");

   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_range_error |-> (rsp_cal_month >= 4'd1) && (rsp_cal_month <= 4'd12)
         && (rsp_cal_day >= 5'd1) && (rsp_cal_hour <= 5'd23) && (rsp_cal_minute <= 6'd59)
         && (rsp_cal_second <= 6'd59) && (rsp_cal_year >= 12'd1970))
      else $error("calendar field out of range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind epoch_seconds_to_calendar_core epcal_checker u_epcal_checker (.*);
